### rtl/hsa_pkg.sv
// shared constants, command and status types for the hue sampler
`timescale 1ns / 1ps
package hsa_pkg;

  // stream geometry
  localparam int STEP_LG = 3;
  localparam int STEP    = 1 << STEP_LG;
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // pixel and glyph widths
  localparam int CH_W    = 8;
  localparam int GLYPH_W = 7;
  localparam logic [GLYPH_W-1:0] GLYPH_WHITE = 7'd32;
  localparam logic [GLYPH_W-1:0] GLYPH_BLACK = 7'd33;
  localparam logic [GLYPH_W-1:0] GLYPH_BASE  = 7'd34;
  localparam logic [CH_W-1:0]    CH_FULL     = 8'd255;

  // hue arithmetic: quotient = 59 * num / (6 * delta), always below 64
  localparam int HUE_SCALE   = 59;
  localparam int HUE_SECTORS = 6;
  localparam int NUM_W       = 11;
  localparam int DIVD_W      = 17;
  localparam int DSR_W       = 11;
  localparam int QBITS       = 6;
  localparam int QCNT_W      = 3;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic emit;
  } hsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sample;
    logic grey;
    logic div_last;
  } hsa_sts_t;

endpackage

### rtl/hsa_ctrl.sv
// sequencing state machine and output valid flag for the hue sampler
`timescale 1ns / 1ps
module hsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hsa_pkg::hsa_sts_t sts,
  output hsa_pkg::hsa_cmd_t cmd
);
  import hsa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.sample) state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.grey ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result held until taken
  assign out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/hsa_datapath.sv
// counters, configuration, hue numerator and shift-subtract divider
`timescale 1ns / 1ps
module hsa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsa_pkg::hsa_cmd_t             cmd,
  output hsa_pkg::hsa_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [hsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsa_pkg::DIM_W-1:0]     cfg_data,
  input  logic [hsa_pkg::CH_W-1:0]      in_red,
  input  logic [hsa_pkg::CH_W-1:0]      in_green,
  input  logic [hsa_pkg::CH_W-1:0]      in_blue,
  output logic [hsa_pkg::GLYPH_W-1:0]   out_glyph,
  output logic                          out_row_end,
  output logic                          out_frame_end
);
  import hsa_pkg::*;

  typedef enum logic [1:0] {
    HUE_RED   = 2'd0,
    HUE_GREEN = 2'd1,
    HUE_BLUE  = 2'd2
  } hue_src_t;

  localparam logic [CNT_W-1:0] STEP_MASK = CNT_W'(STEP - 1);

  // configuration, stored already clamped
  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data == '0) ? DIM_W'(1) :
                       (cfg_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;

  // position counters
  logic [CNT_W-1:0] col_r, row_r;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [DIM_W-1:0] blk_cols, blk_rows, col_blk, row_blk;
  logic             sample, rend, fend;

  assign col_inc  = DIM_W'(col_r) + DIM_W'(1);
  assign row_inc  = DIM_W'(row_r) + DIM_W'(1);
  assign blk_cols = width_r >> STEP_LG;
  assign blk_rows = height_r >> STEP_LG;
  assign col_blk  = DIM_W'(col_r) >> STEP_LG;
  assign row_blk  = DIM_W'(row_r) >> STEP_LG;
  assign sample   = ((col_r & STEP_MASK) == '0) && ((row_r & STEP_MASK) == '0) &&
                    (col_blk < blk_cols) && (row_blk < blk_rows);
  assign rend     = (col_blk == blk_cols - DIM_W'(1));
  assign fend     = rend && (row_blk == blk_rows - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH)  width_r  <= cfg_clamped;
        if (cfg_index == REG_IMAGE_HEIGHT) height_r <= cfg_clamped;
      end
      if (cmd.accept) begin
        if (col_inc >= width_r) begin
          col_r <= '0;
          row_r <= (row_inc >= height_r) ? '0 : row_inc[CNT_W-1:0];
        end else begin
          col_r <= col_inc[CNT_W-1:0];
        end
      end
    end
  end

  // max, min and dominant channel taken with the item
  logic [CH_W-1:0] r_r, g_r, b_r, mx_r, delta_r;
  logic [CH_W-1:0] mx, mn;
  hue_src_t        src, src_r;
  logic            rend_r, fend_r;

  always_comb begin
    if (in_red > in_green) begin
      mx  = in_red;
      mn  = in_green;
      src = HUE_RED;
    end else begin
      mx  = in_green;
      mn  = in_red;
      src = HUE_GREEN;
    end
    if (mx < in_blue) begin
      mx  = in_blue;
      src = HUE_BLUE;
    end
    if (mn > in_blue) mn = in_blue;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_r     <= in_red;
      g_r     <= in_green;
      b_r     <= in_blue;
      mx_r    <= mx;
      delta_r <= mx - mn;
      src_r   <= src;
      rend_r  <= rend;
      fend_r  <= fend;
    end
  end

  // hue numerator scaled by delta, then dividend and divisor
  logic [NUM_W-1:0]  num, d_ext, r_ext, g_ext, b_ext;
  logic [DIVD_W-1:0] dividend;
  logic [DSR_W-1:0]  divisor;
  logic [GLYPH_W-1:0] grey_glyph;

  assign d_ext = NUM_W'(delta_r);
  assign r_ext = NUM_W'(r_r);
  assign g_ext = NUM_W'(g_r);
  assign b_ext = NUM_W'(b_r);

  always_comb begin
    case (src_r)
      HUE_RED:   num = (g_r >= b_r) ? (g_ext - b_ext)
                                    : (NUM_W'(HUE_SECTORS) * d_ext - (b_ext - g_ext));
      HUE_GREEN: num = NUM_W'(2) * d_ext + b_ext - r_ext;
      HUE_BLUE:  num = NUM_W'(4) * d_ext + r_ext - g_ext;
      default:   num = '0;
    endcase
  end

  assign dividend   = DIVD_W'(num) * DIVD_W'(HUE_SCALE);
  assign divisor    = DSR_W'(delta_r) * DSR_W'(HUE_SECTORS);
  assign grey_glyph = (mx_r == CH_FULL) ? GLYPH_WHITE :
                      (mx_r == '0)      ? GLYPH_BLACK : GLYPH_BASE;

  // restoring divider, one quotient bit per cycle
  logic [DIVD_W-1:0]  rem_r, dsh_r;
  logic [QBITS-1:0]   quo_r;
  logic [QCNT_W-1:0]  qcnt_r;
  logic               grey_r;
  logic [GLYPH_W-1:0] grey_glyph_r;
  logic               ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_r        <= dividend;
      dsh_r        <= DIVD_W'(divisor) << (QBITS - 1);
      quo_r        <= '0;
      qcnt_r       <= '0;
      grey_r       <= (delta_r == '0);
      grey_glyph_r <= grey_glyph;
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r  <= dsh_r >> 1;
      quo_r  <= {quo_r[QBITS-2:0], ge};
      qcnt_r <= qcnt_r + QCNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_glyph     <= grey_r ? grey_glyph_r : (GLYPH_BASE + GLYPH_W'(quo_r));
      out_row_end   <= rend_r;
      out_frame_end <= fend_r;
    end
  end

  // status back to the controller
  assign sts.sample   = sample;
  assign sts.grey     = (delta_r == '0);
  assign sts.div_last = (qcnt_r == QCNT_W'(QBITS - 1));

endmodule

### rtl/pixel_hue_to_ascii_sampler_core.sv
// top level of the pixel hue to glyph sampler
`timescale 1ns / 1ps
// Takes one RGB pixel per item in raster order and emits one ASCII glyph for
// each pixel whose column and row are multiples of 8 inside the whole-block
// area, flagged at the end of each glyph row and of the frame. A pixel that
// is not sampled is taken without leaving the idle state. A sampled pixel
// goes through these steps from accept until its glyph is offered: capture
// it and find max/min, form the scaled hue numerator and its multiply by 59,
// run the one-bit-per-cycle shift-subtract divider (skipped for a grey pixel),
// then load the output register. The next pixel is taken as soon as the glyph is
// in the output register, even while it waits for out_ready. The config
// port is always ready; write it only while no item is in flight. Width and
// height of 0 act as 1, above 4096 act as 4096.
module pixel_hue_to_ascii_sampler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsa_pkg::CH_W-1:0]      in_red,
  input  logic [hsa_pkg::CH_W-1:0]      in_green,
  input  logic [hsa_pkg::CH_W-1:0]      in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsa_pkg::GLYPH_W-1:0]   out_glyph,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsa_pkg::DIM_W-1:0]     cfg_data
);
  import hsa_pkg::*;

  hsa_cmd_t cmd;
  hsa_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencing
  hsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and counters
  hsa_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_glyph     (out_glyph),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

endmodule

### rtl/hsa_checker.sv
// port-level checks for the hue sampler, bound to the top level
`timescale 1ns / 1ps
module hsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hsa_pkg::GLYPH_W-1:0] out_glyph,
  input logic                        out_row_end,
  input logic                        out_frame_end
);
  import hsa_pkg::*;

  // no item offered right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_glyph) &&
    $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled output item changed");

  // glyph range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_glyph >= GLYPH_WHITE) && (out_glyph <= 7'd92))
    else $error("glyph out of range");

  // frame end only on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

endmodule

bind pixel_hue_to_ascii_sampler_core hsa_checker u_hsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_glyph     (out_glyph),
  .out_row_end   (out_row_end),
  .out_frame_end (out_frame_end)
);
